// ===== src/allocation_tracking_table_defines.svh =====
// Assertion macros for the allocation tracking table.
// Included by the top level; the macros expect clk_i and rst_ni in scope.
`ifndef ALLOCATION_TRACKING_TABLE_DEFINES_SVH
`define ALLOCATION_TRACKING_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
// The property must hold at every clock edge outside reset.
`define ATT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// The condition must never be true outside reset.
`define ATT_ASSERT_NEVER(lbl, cond, msg) `ATT_ASSERT(lbl, !(cond), msg)
`else
`define ATT_ASSERT(lbl, prop, msg)
`define ATT_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ===== src/att_pkg.sv =====
// Shared types and constants for the allocation tracking table.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package att_pkg;

  // Fixed field widths and constants of the block.
  localparam int unsigned ADDR_W          = 32;
  localparam int unsigned SLOT_W          = 10;
  localparam int unsigned TABLE_DEPTH_DEF = 1024;
  localparam logic [ADDR_W-1:0] LOW_VALID_ADDR = 32'h0000_1000;
  localparam logic [ADDR_W-1:0] LIMIT_RESET    = 32'hFFFF_FFFF;

  // Request kinds.
  localparam logic FUNC_RECORD  = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_UNKNOWN = 2'd2
  } status_e;

  // Read address selection for the table RAM.
  typedef enum logic [2:0] {
    RD_HINT,
    RD_HINT_INC,
    RD_HINT_DEC,
    RD_FIRST,
    RD_NEXT
  } rd_sel_e;

  // Scan counter operations.
  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_ZERO,
    CNT_INC
  } cnt_op_e;

  // Source of the slot number latched with a decision.
  typedef enum logic [2:0] {
    SLOT_ZERO,
    SLOT_HINT,
    SLOT_INC,
    SLOT_DEC,
    SLOT_CNT
  } slot_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      load;
    logic      clear;
    logic      decide;
    logic      commit;
    rd_sel_e   rd_sel;
    cnt_op_e   cnt_op;
    slot_sel_e slot_sel;
    status_e   status;
  } att_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic req_func;
    logic in_func;
    logic addr_zero;
    logic match;
    logic inc_ok;
    logic dec_ok;
    logic cnt_last;
    logic out_free;
  } att_sts_t;

endpackage

`default_nettype wire

// ===== src/allocation_tracking_table.sv =====
// Top level of the allocation tracking table: controller, datapath and assertions.
// Depends on att_pkg, att_ctrl, att_dp, att_ram and allocation_tracking_table_defines.svh.
`default_nettype none

`include "allocation_tracking_table_defines.svh"

// The block keeps TABLE_DEPTH live block addresses in a single-port-read RAM and
// answers one record or release transaction at a time with exactly one result.
// After reset a clearing pass writes zero to every slot, one per cycle, and no
// transaction is taken until it ends; the address limit may be written at any time
// while idle. A record whose hinted slot is vacant, and a release found by one of
// its hint probes, presents its result without a table scan; otherwise the table
// is scanned one slot per cycle through the RAM read port. The longest transaction
// is a release that misses all three probes and then the whole table. A finished
// result waits in an output register, and the next transaction is accepted while
// it waits; a new result is not loaded while the result side stalls a waiting one.
module allocation_tracking_table #(
  parameter int unsigned TABLE_DEPTH = att_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [att_pkg::ADDR_W-1:0]  cfg_wdata_i,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic                        in_func_i,
  input  wire logic [att_pkg::ADDR_W-1:0]  in_block_address_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic      [1:0]                  out_status_o,
  output logic      [att_pkg::SLOT_W-1:0]  out_slot_index_o,
  output logic                             out_out_of_range_o
);

  att_pkg::att_cmd_t cmd;
  att_pkg::att_sts_t sts;
  logic              fail_slot_nonzero;

  // Sequencer.
  att_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Table, hint and result registers.
  att_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_func_i          (in_func_i),
    .in_block_address_i (in_block_address_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_status_o       (out_status_o),
    .out_slot_index_o   (out_slot_index_o),
    .out_out_of_range_o (out_out_of_range_o),
    .cmd_i              (cmd),
    .sts_o              (sts)
  );

  // A failed transaction shown with a nonzero slot.
  assign fail_slot_nonzero = out_valid_o && (out_status_o != att_pkg::ST_DONE) &&
                             (out_slot_index_o != '0);

  // A result is only loaded when the output register is free.
  `ATT_ASSERT(a_commit_free, cmd.commit |-> sts.out_free, "result loaded over a waiting result")
  // A failed transaction reports slot zero.
  `ATT_ASSERT_NEVER(a_fail_slot, fail_slot_nonzero, "nonzero slot on a failed transaction")
  // No reserved status code appears on a valid result.
  `ATT_ASSERT_NEVER(a_status_code, out_valid_o && (out_status_o == 2'd3), "reserved status code")
  // A new result appears only in the cycle after a commit.
  `ATT_ASSERT(a_valid_src, $rose(out_valid_o) |-> $past(cmd.commit), "result without commit")

endmodule

`default_nettype wire

// ===== src/att_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; holds the address table of the allocation tracking table.
`default_nettype none

module att_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; returns the old data on a same-address write.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== src/att_ctrl.sv =====
// Controller state machine of the allocation tracking table.
// Depends on att_pkg for the command and status structs.
`default_nettype none

module att_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire att_pkg::att_sts_t sts_i,
  output att_pkg::att_cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PROBE,
    S_REL_DEC,
    S_REL_HINT,
    S_SCAN,
    S_FINISH
  } state_e;

  state_e state_q, state_d;

  // Requests are taken only in the idle state.
  assign in_stall_o = (state_q != S_IDLE);

  // Next state and commands.
  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.rd_sel   = att_pkg::RD_HINT;
    cmd_o.cnt_op   = att_pkg::CNT_HOLD;
    cmd_o.slot_sel = att_pkg::SLOT_ZERO;
    cmd_o.status   = att_pkg::ST_DONE;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.cnt_last) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.cnt_op = att_pkg::CNT_INC;
        end
      end
      S_IDLE: begin
        // A release probes one above the hint first, a record the hint itself.
        cmd_o.rd_sel = (sts_i.req_func == att_pkg::FUNC_RELEASE) ?
                       att_pkg::RD_HINT_INC : att_pkg::RD_HINT;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_PROBE;
        end
      end
      S_PROBE: begin
        if (sts_i.addr_zero) begin
          cmd_o.decide = 1'b1;
          cmd_o.status = (sts_i.in_func == att_pkg::FUNC_RELEASE) ?
                         att_pkg::ST_UNKNOWN : att_pkg::ST_DONE;
          state_d      = S_FINISH;
        end else if (sts_i.in_func == att_pkg::FUNC_RECORD) begin
          if (sts_i.match) begin
            cmd_o.decide   = 1'b1;
            cmd_o.slot_sel = att_pkg::SLOT_HINT;
            state_d        = S_FINISH;
          end else begin
            cmd_o.rd_sel = att_pkg::RD_FIRST;
            cmd_o.cnt_op = att_pkg::CNT_ZERO;
            state_d      = S_SCAN;
          end
        end else if (sts_i.inc_ok && sts_i.match) begin
          cmd_o.decide   = 1'b1;
          cmd_o.slot_sel = att_pkg::SLOT_INC;
          state_d        = S_FINISH;
        end else begin
          cmd_o.rd_sel = att_pkg::RD_HINT_DEC;
          state_d      = S_REL_DEC;
        end
      end
      S_REL_DEC: begin
        if (sts_i.dec_ok && sts_i.match) begin
          cmd_o.decide   = 1'b1;
          cmd_o.slot_sel = att_pkg::SLOT_DEC;
          state_d        = S_FINISH;
        end else begin
          cmd_o.rd_sel = att_pkg::RD_HINT;
          state_d      = S_REL_HINT;
        end
      end
      S_REL_HINT: begin
        if (sts_i.match) begin
          cmd_o.decide   = 1'b1;
          cmd_o.slot_sel = att_pkg::SLOT_HINT;
          state_d        = S_FINISH;
        end else begin
          cmd_o.rd_sel = att_pkg::RD_FIRST;
          cmd_o.cnt_op = att_pkg::CNT_ZERO;
          state_d      = S_SCAN;
        end
      end
      S_SCAN: begin
        // Each cycle checks one slot while the read of the next is issued.
        if (sts_i.match) begin
          cmd_o.decide   = 1'b1;
          cmd_o.slot_sel = att_pkg::SLOT_CNT;
          state_d        = S_FINISH;
        end else if (sts_i.cnt_last) begin
          cmd_o.decide = 1'b1;
          cmd_o.status = (sts_i.in_func == att_pkg::FUNC_RELEASE) ?
                         att_pkg::ST_UNKNOWN : att_pkg::ST_FULL;
          state_d      = S_FINISH;
        end else begin
          cmd_o.rd_sel = att_pkg::RD_NEXT;
          cmd_o.cnt_op = att_pkg::CNT_INC;
        end
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/att_dp.sv =====
// Datapath of the allocation tracking table: request and result registers,
// hint, scan counter, limit register and the table RAM. Depends on att_pkg, att_ram.
`default_nettype none

module att_dp #(
  parameter int unsigned TABLE_DEPTH = att_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [att_pkg::ADDR_W-1:0]  cfg_wdata_i,
  input  wire logic                        in_func_i,
  input  wire logic [att_pkg::ADDR_W-1:0]  in_block_address_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic      [1:0]                  out_status_o,
  output logic      [att_pkg::SLOT_W-1:0]  out_slot_index_o,
  output logic                             out_out_of_range_o,
  input  wire att_pkg::att_cmd_t           cmd_i,
  output att_pkg::att_sts_t                sts_o
);

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned EXT_W = IDX_W + att_pkg::SLOT_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  logic [att_pkg::ADDR_W-1:0] addr_limit_q;
  logic                       func_q;
  logic [att_pkg::ADDR_W-1:0] addr_q;
  logic                       zero_q;
  logic                       oor_q;
  logic [IDX_W-1:0]           hint_q;
  logic [IDX_W-1:0]           cnt_q;
  logic [IDX_W-1:0]           slot_q;
  att_pkg::status_e           status_q;
  logic                       out_valid_q;
  logic [1:0]                 out_status_q;
  logic [att_pkg::SLOT_W-1:0] out_slot_q;
  logic                       out_oor_q;

  logic [IDX_W-1:0]           hint_inc;
  logic [IDX_W-1:0]           hint_dec;
  logic [IDX_W-1:0]           slot_next;
  logic [IDX_W-1:0]           raddr;
  logic [IDX_W-1:0]           waddr;
  logic [att_pkg::ADDR_W-1:0] wdata;
  logic [att_pkg::ADDR_W-1:0] rdata;
  logic                       we;
  logic                       commit_write;
  logic                       out_free;
  logic                       in_oor;
  logic [IDX_W-1:0]           slot_d;
  logic [EXT_W-1:0]           slot_ext;

  // Address limit register, reset to all ones.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_limit_q <= att_pkg::LIMIT_RESET;
    end else if (cfg_we_i) begin
      addr_limit_q <= cfg_wdata_i;
    end
  end

  // Neighbours of the hint, wrapping at both ends of the table.
  assign hint_inc  = (hint_q == LAST_IDX) ? '0 : hint_q + 1'b1;
  assign hint_dec  = (hint_q == '0) ? LAST_IDX : hint_q - 1'b1;
  assign slot_next = (slot_q == LAST_IDX) ? '0 : slot_q + 1'b1;

  // Range check of the incoming address; only a record is flagged.
  assign in_oor = (in_func_i == att_pkg::FUNC_RECORD) &&
                  ((in_block_address_i < att_pkg::LOW_VALID_ADDR) ||
                   (in_block_address_i >= addr_limit_q));

  // Request registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= in_func_i;
      addr_q <= in_block_address_i;
      zero_q <= (in_block_address_i == '0);
      oor_q  <= in_oor;
    end
  end

  // Read address selection.
  always_comb begin
    unique case (cmd_i.rd_sel)
      att_pkg::RD_HINT:     raddr = hint_q;
      att_pkg::RD_HINT_INC: raddr = hint_inc;
      att_pkg::RD_HINT_DEC: raddr = hint_dec;
      att_pkg::RD_FIRST:    raddr = '0;
      att_pkg::RD_NEXT:     raddr = cnt_q + 1'b1;
      default:              raddr = hint_q;
    endcase
  end

  // Scan and clearing counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      unique case (cmd_i.cnt_op)
        att_pkg::CNT_HOLD: cnt_q <= cnt_q;
        att_pkg::CNT_ZERO: cnt_q <= '0;
        att_pkg::CNT_INC:  cnt_q <= cnt_q + 1'b1;
        default:           cnt_q <= cnt_q;
      endcase
    end
  end

  // Slot chosen by a decision.
  always_comb begin
    unique case (cmd_i.slot_sel)
      att_pkg::SLOT_ZERO: slot_d = '0;
      att_pkg::SLOT_HINT: slot_d = hint_q;
      att_pkg::SLOT_INC:  slot_d = hint_inc;
      att_pkg::SLOT_DEC:  slot_d = hint_dec;
      att_pkg::SLOT_CNT:  slot_d = cnt_q;
      default:            slot_d = '0;
    endcase
  end

  // Decision registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      slot_q   <= slot_d;
      status_q <= cmd_i.status;
    end
  end

  // A successful request on a nonzero address changes the table.
  assign commit_write = cmd_i.commit && (status_q == att_pkg::ST_DONE) && !zero_q;

  // Vacancy hint: past the recorded slot, or on the released slot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hint_q <= '0;
    end else if (commit_write) begin
      hint_q <= (func_q == att_pkg::FUNC_RELEASE) ? slot_q : slot_next;
    end
  end

  // Table RAM write: the clearing pass or the committed update.
  assign we    = cmd_i.clear || commit_write;
  assign waddr = cmd_i.clear ? cnt_q : slot_q;
  assign wdata = (cmd_i.clear || (func_q == att_pkg::FUNC_RELEASE)) ? '0 : addr_q;

  att_ram #(
    .WIDTH (att_pkg::ADDR_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Result register.
  assign out_free = !out_valid_q || !out_stall_i;
  assign slot_ext = {{att_pkg::SLOT_W{1'b0}}, slot_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_status_q <= status_q;
      out_slot_q   <= slot_ext[att_pkg::SLOT_W-1:0];
      out_oor_q    <= oor_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_status_o       = out_status_q;
  assign out_slot_index_o   = out_slot_q;
  assign out_out_of_range_o = out_oor_q;

  // Status towards the controller; the kind of the offered request steers the first probe.
  assign sts_o.req_func  = in_func_i;
  assign sts_o.in_func   = func_q;
  assign sts_o.addr_zero = zero_q;
  assign sts_o.match     = (func_q == att_pkg::FUNC_RELEASE) ? (rdata == addr_q) :
                                                               (rdata == '0);
  assign sts_o.inc_ok    = (hint_q != LAST_IDX);
  assign sts_o.dec_ok    = (hint_q != '0);
  assign sts_o.cnt_last  = (cnt_q == LAST_IDX);
  assign sts_o.out_free  = out_free;

endmodule

`default_nettype wire

// ===== verif/att_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the allocation tracking table: watches the limit register and both channels.
// It predicts each result from a shadow table and compares it; depends on att_pkg.
module att_checker
  import att_pkg::*;
#(
  parameter int unsigned DEPTH = TABLE_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [ADDR_W-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic              in_func_i,
  input  logic [ADDR_W-1:0] in_block_address_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [1:0]        out_status_i,
  input  logic [SLOT_W-1:0] out_slot_index_i,
  input  logic              out_out_of_range_i,
  output int                fail_count_o,
  output int                pending_o,
  output int                checked_o
);

  // One result as the block should present it.
  typedef struct packed {
    status_e           status;
    logic [SLOT_W-1:0] slot;
    logic              oor;
  } outcome_t;

  logic [ADDR_W-1:0] shadow_table [DEPTH];
  int unsigned       shadow_hint;
  logic [ADDR_W-1:0] shadow_limit;
  outcome_t          due_outcomes [$];

  // Advance a slot number, wrapping to zero past the last slot.
  function automatic int unsigned step_slot(int unsigned s);
    return (s + 1 >= DEPTH) ? 0 : s + 1;
  endfunction

  // Record an allocated block: the hinted slot if vacant, else the lowest vacant one.
  function automatic outcome_t record_block(logic [ADDR_W-1:0] addr);
    outcome_t    res;
    int unsigned s;
    res.status = ST_DONE;
    res.slot   = '0;
    res.oor    = (addr < LOW_VALID_ADDR) || (addr >= shadow_limit);
    // Zero already marks a vacant slot, so nothing is stored.
    if (addr == '0) return res;
    if (shadow_table[shadow_hint] == '0) begin
      s = shadow_hint;
      shadow_table[s] = addr;
      shadow_hint = step_slot(s);
      res.slot = s[SLOT_W-1:0];
      return res;
    end
    for (int i = 0; i < DEPTH; i++) begin
      if (shadow_table[i] == '0) begin
        shadow_table[i] = addr;
        shadow_hint = step_slot(i);
        res.slot = i[SLOT_W-1:0];
        return res;
      end
    end
    // The table is full: nothing changes but the range flag is still given.
    res.status = ST_FULL;
    return res;
  endfunction

  // Release a block: probe hint+1, hint-1 and hint, then the lowest matching slot.
  function automatic outcome_t release_block(logic [ADDR_W-1:0] addr);
    outcome_t    res;
    int unsigned h;
    int unsigned s;
    bit          found;
    res.status = ST_UNKNOWN;
    res.slot   = '0;
    res.oor    = 1'b0;
    h = shadow_hint;
    s = 0;
    found = 1'b0;
    if (addr != '0) begin
      if (h < DEPTH - 1 && shadow_table[h + 1] == addr) begin
        s = h + 1;
        found = 1'b1;
      end else if (h > 0 && shadow_table[h - 1] == addr) begin
        s = h - 1;
        found = 1'b1;
      end else if (shadow_table[h] == addr) begin
        s = h;
        found = 1'b1;
      end else begin
        for (int i = 0; i < DEPTH; i++) begin
          if (shadow_table[i] == addr) begin
            s = i;
            found = 1'b1;
            break;
          end
        end
      end
    end
    if (found) begin
      shadow_table[s] = '0;
      shadow_hint = s;
      res.status = ST_DONE;
      res.slot = s[SLOT_W-1:0];
    end
    return res;
  endfunction

  // Print one line per mismatch and count it.
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    fail_count_o++;
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // Results are checked before the transaction accepted at the same edge is predicted.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    outcome_t want;
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) shadow_table[i] = '0;
      shadow_hint  = 0;
      shadow_limit = LIMIT_RESET;
      due_outcomes.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) shadow_limit = cfg_wdata_i;
      if (out_valid_i && !out_stall_i) begin
        checked_o++;
        if (due_outcomes.size() == 0) begin
          report_mismatch("result with nothing outstanding", out_status_i, '0);
        end else begin
          want = due_outcomes.pop_front();
          if (out_status_i !== want.status) report_mismatch("status", out_status_i, want.status);
          if (out_slot_index_i !== want.slot)
            report_mismatch("slot_index", out_slot_index_i, want.slot);
          if (out_out_of_range_i !== want.oor)
            report_mismatch("out_of_range", out_out_of_range_i, want.oor);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (in_func_i == FUNC_RECORD) due_outcomes.push_back(record_block(in_block_address_i));
        else due_outcomes.push_back(release_block(in_block_address_i));
      end
      pending_o <= due_outcomes.size();
    end
  end

endmodule

// ===== verif/allocation_tracking_table_tb.sv =====
`timescale 1ns / 100ps
// Top of the allocation tracking table testbench: clock, reset, stimulus and verdict.
// Depends on att_pkg, allocation_tracking_table and att_checker.
module allocation_tracking_table_tb;
  import att_pkg::*;

  localparam int unsigned DEPTH = TABLE_DEPTH_DEF;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 150;
  localparam int TIMEOUT_NS  = 120_000_000;

  logic              clk_i              = 1'b0;
  logic              rst_ni             = 1'b0;
  logic              cfg_we_i           = 1'b0;
  logic [ADDR_W-1:0] cfg_wdata_i        = '0;
  logic              in_valid_i         = 1'b0;
  logic              in_func_i          = FUNC_RECORD;
  logic [ADDR_W-1:0] in_block_address_i = '0;
  logic              out_stall_i        = 1'b0;
  logic              in_stall_o;
  logic              out_valid_o;
  logic [1:0]        out_status_o;
  logic [SLOT_W-1:0] out_slot_index_o;
  logic              out_out_of_range_o;

  int                fail_count;
  int                pending;
  int                checked;
  bit                quiet         = 1'b0;
  int                hold_requests = 0;
  int                holds_served  = 0;
  int                n_record      = 0;
  int                n_release     = 0;
  logic [ADDR_W-1:0] live_addrs [$];

  allocation_tracking_table #(
    .TABLE_DEPTH (DEPTH)
  ) DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .in_func_i          (in_func_i),
    .in_block_address_i (in_block_address_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_status_o       (out_status_o),
    .out_slot_index_o   (out_slot_index_o),
    .out_out_of_range_o (out_out_of_range_o)
  );

  att_checker #(
    .DEPTH (DEPTH)
  ) u_att_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_i         (in_stall_o),
    .in_func_i          (in_func_i),
    .in_block_address_i (in_block_address_i),
    .out_valid_i        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_status_i       (out_status_o),
    .out_slot_index_i   (out_slot_index_o),
    .out_out_of_range_i (out_out_of_range_o),
    .fail_count_o       (fail_count),
    .pending_o          (pending),
    .checked_o          (checked)
  );

  // 20 ns clock.
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #TIMEOUT_NS;
    $display("Verification failed");
    $finish;
  end

  // Result side: random stalls, none while quiet, and long hold-offs on request.
  initial begin : receiver
    forever begin
      @(posedge clk_i);
      if (holds_served != hold_requests) begin
        holds_served++;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        out_stall_i <= !quiet && ($urandom_range(0, 99) < 20);
      end
    end
  end

  // Offer one transaction, after an occasional random gap, and wait until it is taken.
  task automatic issue_request(logic func, logic [ADDR_W-1:0] addr);
    if (!quiet && $urandom_range(0, 99) < 20) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    in_func_i          <= func;
    in_block_address_i <= addr;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    if (func == FUNC_RECORD) begin
      n_record++;
      if (addr != '0) live_addrs.push_back(addr);
    end else begin
      n_release++;
    end
  endtask

  // Stop offering and wait until every outstanding result has been taken.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Write the address limit; only called while the block is idle.
  task automatic write_limit(logic [ADDR_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Small address pool so that duplicates and re-use are common.
  function automatic logic [ADDR_W-1:0] pool_address();
    return LOW_VALID_ADDR + ($urandom_range(0, 255) << 4);
  endfunction

  function automatic logic [ADDR_W-1:0] random_record_address();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return $urandom_range(1, 32'hFFF);
      default: return pool_address();
    endcase
  endfunction

  // Mostly records and releases of live blocks, with unknown and zero addresses as noise.
  task automatic random_phase(int count, int hold_at);
    int                pick;
    int                idx;
    logic [ADDR_W-1:0] addr;
    for (int k = 0; k < count; k++) begin
      if (k == hold_at) hold_requests++;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        issue_request(FUNC_RECORD, random_record_address());
      end else if (pick < 75 && live_addrs.size() != 0) begin
        idx  = $urandom_range(0, live_addrs.size() - 1);
        addr = live_addrs[idx];
        live_addrs.delete(idx);
        issue_request(FUNC_RELEASE, addr);
      end else if (pick < 90) begin
        issue_request(FUNC_RELEASE, pool_address());
      end else if (pick < 95) begin
        issue_request(logic'($urandom_range(0, 1)), '0);
      end else begin
        issue_request(FUNC_RELEASE, $urandom());
      end
    end
  endtask

  initial begin : stimulus
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Let the clearing pass after reset finish.
    repeat (DEPTH + 16) @(posedge clk_i);
    write_limit(32'h8000_0000);

    // Range boundaries, address zero and the all-ones address.
    issue_request(FUNC_RECORD, 32'h0000_1000);
    issue_request(FUNC_RECORD, 32'h0000_0FFF);
    issue_request(FUNC_RECORD, 32'h0000_0000);
    issue_request(FUNC_RECORD, 32'hFFFF_FFFF);
    issue_request(FUNC_RECORD, 32'h7FFF_FFFF);
    issue_request(FUNC_RECORD, 32'h8000_0000);
    issue_request(FUNC_RELEASE, 32'h0000_0000);
    issue_request(FUNC_RELEASE, 32'h1234_5678);
    // Duplicates, a release found by scanning and one found below the hint.
    issue_request(FUNC_RECORD, 32'h0000_2000);
    issue_request(FUNC_RECORD, 32'h0000_2000);
    issue_request(FUNC_RECORD, 32'h0000_3000);
    issue_request(FUNC_RELEASE, 32'h0000_2000);
    issue_request(FUNC_RELEASE, 32'h0000_3000);
    issue_request(FUNC_RELEASE, 32'h0000_2000);
    issue_request(FUNC_RELEASE, 32'h0000_2000);
    // Hinted record, release above the hint and release at the hint itself.
    issue_request(FUNC_RECORD, 32'h0000_4000);
    issue_request(FUNC_RELEASE, 32'h7FFF_FFFF);
    issue_request(FUNC_RELEASE, 32'h8000_0000);
    issue_request(FUNC_RECORD, 32'hFFFF_F000);
    issue_request(FUNC_RECORD, 32'h0000_5000);
    issue_request(FUNC_RELEASE, 32'h0000_4000);
    issue_request(FUNC_RELEASE, 32'hFFFF_FFFF);

    // A zero limit flags every record.
    drain();
    write_limit('0);
    issue_request(FUNC_RECORD, 32'h0000_1000);
    issue_request(FUNC_RECORD, 32'hFFFF_FFFF);

    // Random traffic under three limits, with hold-offs and a stretch without idling.
    drain();
    write_limit($urandom());
    random_phase(PHASE_ITEMS, 20);
    drain();
    write_limit(LOW_VALID_ADDR);
    quiet = 1'b1;
    random_phase(PHASE_ITEMS, -1);
    quiet = 1'b0;
    drain();
    write_limit($urandom_range(32'h1000, 32'h2000));
    random_phase(PHASE_ITEMS, 60);

    drain();
    repeat (DEPTH + 8) @(posedge clk_i);
    $display("Run covered %0d record and %0d release transactions, %0d results checked,",
             n_record, n_release, checked);
    $display("including hint probes, table scans, long output hold-offs and a zero limit.");
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
